// ===== design/cbts_pkg.sv =====
package cbts_pkg;

    localparam int CLK_W      = 28;
    localparam int CNT_W      = 5;
    localparam int DIV_W      = 4;
    localparam int QM_W       = 5;
    localparam int SEG_W      = 5;
    localparam int QD_W       = 10;
    localparam int PROD_W     = 14;
    localparam int WORD_W     = 15;
    localparam int SEGS_FIRST = 3;
    localparam int SEGS_LAST  = 17;
    localparam int QM_LAST    = 31;
    localparam int DIV_LAST   = 15;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd12000000;

    typedef struct packed {
        logic             found;
        logic [DIV_W-1:0] div;
        logic [QM_W-1:0]  qm1;
        logic [SEG_W-1:0] segs;
    } t_hit;

    function automatic logic [WORD_W-1:0] pack_timing(input logic [QM_W-1:0] qm1,
                                                      input logic [SEG_W-1:0] segs);
        logic [3:0] rest;
        logic [2:0] tseg1;
        logic [2:0] tseg2;
        logic [1:0] sjw;
        rest  = 4'(segs - SEG_W'(SEGS_FIRST));
        tseg1 = rest[3:1];
        tseg2 = 3'(rest - {1'b0, tseg1});
        sjw   = (tseg1 > 3'd3) ? 2'd3 : tseg1[1:0];
        return {tseg2, 1'b0, tseg1, sjw, 1'b0, qm1};
    endfunction

endpackage

// ===== design/can_bit_timing_search_top.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_baud_rate
// out      output     o_out_valid / i_out_stall o_found, o_prescaler, o_timing_word
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_clock_rate
//
// A nonzero rate runs through the bit-serial divider, then one cycle per
// candidate of the shared multiply-compare unit, up to 7680, then through the hold state.
// A zero rate skips the divider and the search and goes to the hold state with a
// cleared result. Reset sets control state and the default clock rate, not the result.
// The input stalls while a beat is in work; the result waits in the output
// register, and a new beat is accepted while it waits.
module can_bit_timing_search_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [cbts_pkg::CLK_W-1:0]  i_baud_rate,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [cbts_pkg::DIV_W-1:0]  o_prescaler,
    output logic [cbts_pkg::WORD_W-1:0] o_timing_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cbts_pkg::CLK_W-1:0]  i_cfg_clock_rate
);
    import cbts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SRCH = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state            r_state;
    logic [CLK_W-1:0]  r_clock_rate;
    logic              r_pend_found;
    logic [DIV_W-1:0]  r_pend_prescaler;
    logic [WORD_W-1:0] r_pend_word;
    logic              r_out_valid;
    logic              r_out_found;
    logic [DIV_W-1:0]  r_out_prescaler;
    logic [WORD_W-1:0] r_out_word;
    logic              in_accept;
    logic              div_start;
    logic              div_done;
    logic [CLK_W-1:0]  quot;
    logic              srch_start;
    logic              srch_done;
    t_hit              hit;
    logic              out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign div_start  = in_accept && (i_baud_rate != '0);
    assign srch_start = (r_state == S_DIV) && div_done;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    cbts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_clock_rate),
        .i_den   (i_baud_rate),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    cbts_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_per_bit (quot),
        .o_done    (srch_done),
        .o_hit     (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= CLK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clock_rate <= i_cfg_clock_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else if (in_accept) begin
                        r_state <= S_HOLD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (srch_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && !div_start) begin
            r_pend_found     <= 1'b0;
            r_pend_prescaler <= '0;
            r_pend_word      <= '0;
        end else if (r_state == S_SRCH && srch_done) begin
            r_pend_found     <= hit.found;
            r_pend_prescaler <= hit.found ? hit.div : '0;
            r_pend_word      <= hit.found ? pack_timing(hit.qm1, hit.segs) : '0;
        end
        if (r_state == S_HOLD && out_free) begin
            r_out_found     <= r_pend_found;
            r_out_prescaler <= r_pend_prescaler;
            r_out_word      <= r_pend_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_prescaler   = r_out_prescaler;
    assign o_timing_word = r_out_word;

    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result shown without a finished search");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_prescaler == '0 && r_out_word == '0)
        else $error("miss carries nonzero timing");

endmodule

// ===== design/cbts_div.sv =====
module cbts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cbts_pkg::CLK_W-1:0] i_num,
    input  logic [cbts_pkg::CLK_W-1:0] i_den,
    output logic                       o_done,
    output logic [cbts_pkg::CLK_W-1:0] o_quot
);
    import cbts_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CLK_W-1:0] r_rem;
    logic [CLK_W-1:0] r_quot;
    logic [CLK_W-1:0] r_den;
    logic [CLK_W:0]   shifted;
    logic [CLK_W:0]   diff;
    logic             ge;

    assign shifted = {r_rem, r_quot[CLK_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = !diff[CLK_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CLK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[CLK_W-1:0] : shifted[CLK_W-1:0];
            r_quot <= {r_quot[CLK_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

endmodule

// ===== design/cbts_search.sv =====
module cbts_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cbts_pkg::CLK_W-1:0] i_per_bit,
    output logic                       o_done,
    output cbts_pkg::t_hit             o_hit
);
    import cbts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_sstate;

    t_sstate           r_state;
    logic              r_done;
    t_hit              r_hit;
    logic [CLK_W-1:0]  r_per_bit;
    logic [DIV_W-1:0]  r_div;
    logic [QM_W-1:0]   r_qm1;
    logic [SEG_W-1:0]  r_segs;
    logic [QD_W-1:0]   r_qd;
    logic [PROD_W-1:0] r_prod;
    logic              match;
    logic [QD_W-1:0]   div_inc;
    logic [QD_W-1:0]   qd_step;
    logic [QD_W-1:0]   qd_next_div;

    assign match       = ({{(CLK_W-PROD_W){1'b0}}, r_prod} == r_per_bit);
    assign div_inc     = QD_W'(r_div) + QD_W'(1);
    assign qd_step     = r_qd + div_inc;
    assign qd_next_div = div_inc + QD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (match || (r_segs == SEG_W'(SEGS_LAST) && r_qm1 == QM_W'(QM_LAST)
                                  && r_div == DIV_W'(DIV_LAST))) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_per_bit <= i_per_bit;
            r_div     <= '0;
            r_qm1     <= '0;
            r_segs    <= SEG_W'(SEGS_FIRST);
            r_qd      <= QD_W'(1);
            r_prod    <= PROD_W'(SEGS_FIRST);
        end else if (r_state == S_RUN) begin
            if (match) begin
                r_hit <= '{found: 1'b1, div: r_div, qm1: r_qm1, segs: r_segs};
            end else if (r_segs != SEG_W'(SEGS_LAST)) begin
                r_segs <= r_segs + 1'b1;
                r_prod <= r_prod + PROD_W'(r_qd);
            end else if (r_qm1 != QM_W'(QM_LAST)) begin
                r_segs <= SEG_W'(SEGS_FIRST);
                r_qm1  <= r_qm1 + 1'b1;
                r_qd   <= qd_step;
                r_prod <= PROD_W'({qd_step, 1'b0}) + PROD_W'(qd_step);
            end else if (r_div != DIV_W'(DIV_LAST)) begin
                r_segs <= SEG_W'(SEGS_FIRST);
                r_qm1  <= '0;
                r_div  <= r_div + 1'b1;
                r_qd   <= qd_next_div;
                r_prod <= PROD_W'({qd_next_div, 1'b0}) + PROD_W'(qd_next_div);
            end else begin
                r_hit <= '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;

    a_qd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_qd == QD_W'((QD_W'(r_qm1) + QD_W'(1)) * (QD_W'(r_div) + QD_W'(1))))
        else $error("quanta times divider product out of step");

    a_prod_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_prod == PROD_W'(PROD_W'(r_qd) * PROD_W'(r_segs)))
        else $error("candidate product out of step");

    a_done_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_RUN))
        else $error("search finished without running");

endmodule
